// File: rtl/yuva_alpha_over_blend_macros.svh
// Assertion helpers for the checker of the alpha blender.
`ifndef YUVA_ALPHA_OVER_BLEND_MACROS_SVH
`define YUVA_ALPHA_OVER_BLEND_MACROS_SVH

// Clocked check, silenced while reset is asserted.
`define YAOB_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define YAOB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/yaob_pkg.sv
package yaob_pkg;

  // Request selectors
  localparam logic [1:0] CMD_LUMA   = 2'd0;
  localparam logic [1:0] CMD_ALPHA  = 2'd1;
  localparam logic [1:0] CMD_CHROMA = 2'd2;

  // Result kinds
  localparam logic KIND_LUMA   = 1'b0;
  localparam logic KIND_CHROMA = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [2:0] TILE_FULL    = 3'd4;
  localparam logic [2:0] TILE_HALF    = 3'd2;
  localparam logic [2:0] TILE_THREE   = 3'd3;

  // Reciprocal 2^24 / blend: one quotient bit per divider step
  localparam int DIV_STEPS = 25;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] src_a;
    logic [7:0] dst_a;
    logic [7:0] src_luma;
    logic [7:0] dst_luma;
    logic [7:0] src_cb;
    logic [7:0] src_cr;
    logic [7:0] dst_cb;
    logic [7:0] dst_cr;
  } in_req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_luma;
    logic [7:0] out_alpha;
    logic [7:0] out_cb;
    logic [7:0] out_cr;
  } out_req_t;

  typedef struct packed {
    logic load_luma;
    logic load_chroma;
    logic acc_alpha;
    logic tmp_en;
    logic prod_en;
    logic div_init;
    logic div_step;
    logic div_first;
    logic mul_en;
    logic res_load;
  } dp_cmd_t;

endpackage

// File: rtl/yaob_datapath.sv
module yaob_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  yaob_pkg::in_req_t in_data,
  input  yaob_pkg::dp_cmd_t cmd,
  output yaob_pkg::out_req_t out_data
);
  import yaob_pkg::*;

  // Tile alpha accumulation
  logic [9:0]  src_sum_r, dst_sum_r;
  logic [2:0]  count_r;
  logic [10:0] src_round, dst_round;

  // Operands of the request at work
  logic        kind_r;
  logic [7:0]  sa_r, da_r, s0_r, d0_r, s1_r, d1_r;
  logic [7:0]  tmp_r, blend_r;
  logic [15:0] pa_r, pb_r, pc_r, pd_r;
  logic [16:0] num0_r, num1_r;
  logic [7:0]  rem_r;
  logic [24:0] quo_r;
  logic [7:0]  y0_r, y1_r;
  out_req_t    out_r;

  logic [8:0]  inv_sa;
  logic [16:0] tmp_prod;
  logic [8:0]  blend_sum;
  logic [8:0]  trial, diff;
  logic        ge;
  logic [41:0] mul0, mul1;
  logic [7:0]  res0, res1, res_alpha;

  always_comb begin
    priority if (count_r >= TILE_THREE) begin
      src_round = ({1'b0, src_sum_r} + 11'd3) >> 2;
      dst_round = ({1'b0, dst_sum_r} + 11'd3) >> 2;
    end else if (count_r == TILE_HALF) begin
      src_round = ({1'b0, src_sum_r} + 11'd1) >> 1;
      dst_round = ({1'b0, dst_sum_r} + 11'd1) >> 1;
    end else begin
      src_round = {1'b0, src_sum_r};
      dst_round = {1'b0, dst_sum_r};
    end
  end

  assign inv_sa    = 9'd256 - {1'b0, sa_r};
  assign tmp_prod  = {9'd0, da_r} * {8'd0, inv_sa};
  assign blend_sum = {1'b0, sa_r} + {1'b0, tmp_r};
  assign trial     = {rem_r, cmd.div_first};
  assign ge        = trial >= {1'b0, blend_r};
  assign diff      = trial - {1'b0, blend_r};
  assign mul0      = {25'd0, num0_r} * {17'd0, quo_r};
  assign mul1      = {25'd0, num1_r} * {17'd0, quo_r};

  // Opaque copies the source, transparent keeps the destination, else the blend
  always_comb begin
    priority if (sa_r == ALPHA_OPAQUE) begin
      res0      = s0_r;
      res1      = s1_r;
      res_alpha = ALPHA_OPAQUE;
    end else if (sa_r == ALPHA_CLEAR) begin
      res0      = d0_r;
      res1      = d1_r;
      res_alpha = da_r;
    end else begin
      res0      = y0_r;
      res1      = y1_r;
      res_alpha = blend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_sum_r <= '0;
      dst_sum_r <= '0;
      count_r   <= '0;
    end else if (cmd.acc_alpha && count_r < TILE_FULL) begin
      src_sum_r <= src_sum_r + {2'd0, in_data.src_a};
      dst_sum_r <= dst_sum_r + {2'd0, in_data.dst_a};
      count_r   <= count_r + 3'd1;
    end else if (cmd.load_chroma) begin
      src_sum_r <= '0;
      dst_sum_r <= '0;
      count_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_luma) begin
      kind_r <= KIND_LUMA;
      sa_r   <= in_data.src_a;
      da_r   <= in_data.dst_a;
      s0_r   <= in_data.src_luma;
      d0_r   <= in_data.dst_luma;
      s1_r   <= in_data.src_luma;
      d1_r   <= in_data.dst_luma;
    end
    if (cmd.load_chroma) begin
      kind_r <= KIND_CHROMA;
      sa_r   <= src_round[7:0];
      da_r   <= dst_round[7:0];
      s0_r   <= in_data.src_cb;
      d0_r   <= in_data.dst_cb;
      s1_r   <= in_data.src_cr;
      d1_r   <= in_data.dst_cr;
    end
    if (cmd.tmp_en) begin
      tmp_r <= tmp_prod[15:8];
    end
    if (cmd.prod_en) begin
      blend_r <= blend_sum[7:0];
      pa_r    <= {8'd0, s0_r} * {8'd0, sa_r};
      pb_r    <= {8'd0, d0_r} * {8'd0, tmp_r};
      pc_r    <= {8'd0, s1_r} * {8'd0, sa_r};
      pd_r    <= {8'd0, d1_r} * {8'd0, tmp_r};
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? diff[7:0] : trial[7:0];
      quo_r <= {quo_r[23:0], ge};
    end
    if (cmd.div_first) begin
      num0_r <= {1'b0, pa_r} + {1'b0, pb_r};
      num1_r <= {1'b0, pc_r} + {1'b0, pd_r};
    end
    if (cmd.mul_en) begin
      y0_r <= mul0[31:24];
      y1_r <= mul1[31:24];
    end
    if (cmd.res_load) begin
      out_r.kind <= kind_r;
      if (kind_r == KIND_LUMA) begin
        out_r.out_luma  <= res0;
        out_r.out_alpha <= res_alpha;
        out_r.out_cb    <= '0;
        out_r.out_cr    <= '0;
      end else begin
        out_r.out_luma  <= '0;
        out_r.out_alpha <= '0;
        out_r.out_cb    <= res0;
        out_r.out_cr    <= res1;
      end
    end
  end

  assign out_data = out_r;

endmodule

// File: rtl/yaob_ctrl.sv
module yaob_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output yaob_pkg::dp_cmd_t cmd
);
  import yaob_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_TMP, S_NUM, S_DIV, S_MUL, S_OUT
  } state_t;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_INC  = DIV_CNT_W'(1);

  state_t                state_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic                  out_valid_r;
  logic                  in_accept;
  logic                  out_free;

  assign in_accept = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_luma   = in_accept && (in_cmd == CMD_LUMA);
        cmd.load_chroma = in_accept && (in_cmd == CMD_CHROMA);
        cmd.acc_alpha   = in_accept && (in_cmd == CMD_ALPHA);
      end
      S_TMP: cmd.tmp_en = 1'b1;
      S_NUM: begin
        cmd.prod_en  = 1'b1;
        cmd.div_init = 1'b1;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (div_cnt_r == '0);
      end
      S_MUL: cmd.mul_en   = 1'b1;
      S_OUT: cmd.res_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on a fresh load, drop it once the result is taken
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept && (in_cmd == CMD_LUMA || in_cmd == CMD_CHROMA)) begin
            state_r <= S_TMP;
          end
        end
        S_TMP: state_r <= S_NUM;
        S_NUM: begin
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt_r == DIV_LAST) begin
            div_cnt_r <= '0;
            state_r   <= S_MUL;
          end else begin
            div_cnt_r <= div_cnt_r + DIV_INC;
          end
        end
        S_MUL: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/yuva_alpha_over_blend.sv
// Alpha blender for a non-premultiplied YUVA 4:2:0 source over a destination.
// A luma request (cmd 0) returns the blended luma and the new destination
// alpha. Chroma works per tile: alpha-sample requests (cmd 1) add source and
// destination alpha into running sums (at most four samples count, later ones
// are dropped), and a finish request (cmd 2) ceil-averages the sums (three
// samples are divided by four), blends U and V with them and clears the
// sums. A source alpha of 255 copies the source, 0 keeps the destination;
// anything else divides by the blended alpha through a reciprocal
// floor(2^24 / blend). Requests with cmd 1 or 3 give no result and leave the
// block ready for another request. A luma or finish request keeps the input
// stalled from acceptance on through operand capture, the destination weight,
// the partial products, 25 steps of the restoring divider that forms the
// reciprocal one quotient bit a cycle, the final multiply and the load of the
// output register. A result waiting in the output register does not hold off
// the next request until a second result is ready to be loaded.
module yuva_alpha_over_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  yaob_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output yaob_pkg::out_req_t out_data
);
  import yaob_pkg::*;

  dp_cmd_t dp_cmd;

  // Sequence each request through the datapath
  yaob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd)
  );

  // Hold tile sums, operands, divider and the output register
  yaob_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .out_data (out_data)
  );

endmodule

// File: rtl/yaob_checker.sv
`include "yuva_alpha_over_blend_macros.svh"

module yaob_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input yaob_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input yaob_pkg::out_req_t out_data
);
  import yaob_pkg::*;

  logic blend_req;

  assign blend_req = in_valid && !in_stall &&
                     (in_data.cmd == CMD_LUMA || in_data.cmd == CMD_CHROMA);

  // A stalled result holds
  `YAOB_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // Reset leaves the block idle with nothing to deliver
  `YAOB_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

  // A blend request keeps the input side busy while it is worked on
  `YAOB_ASSERT_CLK(a_busy, blend_req |=> in_stall, "blend request did not stall input")

  // A fresh result comes only from a request at work
  `YAOB_ASSERT_CLK(a_rise_busy, $rose(out_valid) |-> $past(in_stall), "result without request")

endmodule

bind yuva_alpha_over_blend yaob_checker u_chk (.*);
